// File: rtl/tcbe_pkg.sv
// ----------------------------------------------------------------------------
// tcbe_pkg
// types and constants shared by the transport stream bitrate estimator
// ----------------------------------------------------------------------------
package tcbe_pkg;

    localparam int PID_W      = 13;
    localparam int CC_W       = 4;
    localparam int CLK_W      = 42;
    localparam int DTS_W      = 33;
    localparam int PKT_W      = 40;
    localparam int PCNT_W     = 32;
    localparam int SMP_W      = 16;
    localparam int PIDN_W     = 14;
    localparam int EPOCH_W    = 8;
    localparam int RATE_W     = 32;
    localparam int SUM_W      = 64;
    localparam int NUM_W      = 76;
    localparam int DEN_W      = 42;
    localparam int KONST_W    = 36;
    localparam int MUL_SPLIT  = 20;
    localparam int PROD_W     = MUL_SPLIT + KONST_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // 27 MHz system clock, dts ticks are 300 system clock ticks
    localparam logic [CLK_W-1:0]   CLK_SUBFACTOR = 42'd300;
    // system clock frequency times packet size times 8 bits
    localparam logic [KONST_W-1:0] RATE_K188 = 36'd40608000000;
    localparam logic [KONST_W-1:0] RATE_K204 = 36'd44064000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_USE_DTS           = 4'd0,
        REG_IGNORE_ERRORS     = 4'd1,
        REG_MIN_PIDS          = 4'd2,
        REG_MIN_CLOCK_SAMPLES = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              use_dts;
        logic              ignore_errors;
        logic [PIDN_W-1:0] min_pids;
        logic [SMP_W-1:0]  min_clock_samples;
    } cfg_t;

    typedef struct packed {
        logic             sync_ok;
        logic [PID_W-1:0] pid;
        logic [CC_W-1:0]  cc;
        logic             disc;
        logic             payload;
        logic             has_clk;
        logic [CLK_W-1:0] clk;
    } item_t;

    typedef struct packed {
        logic [PCNT_W-1:0] pkts;
        logic [CC_W-1:0]   cc;
        logic [SMP_W-1:0]  smp;
    } cnt_row_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [CLK_W-1:0]   clk;
        logic [PKT_W-1:0]   pkt;
    } clk_row_t;

    typedef struct packed {
        logic              rate_valid;
        logic [RATE_W-1:0] avg_rate_188;
        logic [RATE_W-1:0] avg_rate_204;
        logic [PKT_W-1:0]  packet_total;
        logic [RATE_W-1:0] rate_sample_total;
        logic [PIDN_W-1:0] clock_pid_total;
        logic [PCNT_W-1:0] pid_packets;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_WIPE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_DIV188,
        ST_DIV204,
        ST_ACC,
        ST_AVG188,
        ST_AVG204,
        ST_OUT
    } state_t;

endpackage

// File: rtl/tcbe_if.sv
// ----------------------------------------------------------------------------
// tcbe interfaces
// packet header, result and configuration channels
// ----------------------------------------------------------------------------
interface tcbe_in_if
    import tcbe_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic             sync_ok;
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cont_counter;
    logic             disc_flag;
    logic             has_payload;
    logic             has_pcr;
    logic [CLK_W-1:0] pcr_value;
    logic             has_dts;
    logic [DTS_W-1:0] dts_value;

    modport source (output valid, sync_ok, pid, cont_counter, disc_flag, has_payload,
                    has_pcr, pcr_value, has_dts, dts_value, input ready);
    modport sink (input valid, sync_ok, pid, cont_counter, disc_flag, has_payload,
                  has_pcr, pcr_value, has_dts, dts_value, output ready);
endinterface

interface tcbe_out_if
    import tcbe_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              rate_valid;
    logic [RATE_W-1:0] avg_rate_188;
    logic [RATE_W-1:0] avg_rate_204;
    logic [PKT_W-1:0]  packet_total;
    logic [RATE_W-1:0] rate_sample_total;
    logic [PIDN_W-1:0] clock_pid_total;
    logic [PCNT_W-1:0] pid_packets;

    modport source (output valid, rate_valid, avg_rate_188, avg_rate_204, packet_total,
                    rate_sample_total, clock_pid_total, pid_packets, input ready);
    modport sink (input valid, rate_valid, avg_rate_188, avg_rate_204, packet_total,
                  rate_sample_total, clock_pid_total, pid_packets, output ready);
endinterface

interface tcbe_cfg_if
    import tcbe_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/tcbe_front.sv
// ----------------------------------------------------------------------------
// tcbe_front
// accepts packet headers, selects the clock, queues items for the core
// ----------------------------------------------------------------------------
module tcbe_front
    import tcbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tcbe_in_if.sink    pkt_in,
    input  cfg_t       cfg,
    output logic       item_valid,
    input  logic       item_ready,
    output item_t      item
);

    item_t       q_mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       new_item;
    logic        push, pop;

    always_comb
    begin
        new_item.sync_ok = pkt_in.sync_ok;
        new_item.pid     = pkt_in.pid;
        new_item.cc      = pkt_in.cont_counter;
        new_item.disc    = pkt_in.disc_flag;
        new_item.payload = pkt_in.has_payload;
        new_item.has_clk = cfg.use_dts ? pkt_in.has_dts : pkt_in.has_pcr;
        new_item.clk     = cfg.use_dts ? CLK_W'(pkt_in.dts_value) * CLK_SUBFACTOR
                                       : pkt_in.pcr_value;
    end

    assign pkt_in.ready = (count_reg != 2'd2);
    assign push         = pkt_in.valid && pkt_in.ready;
    assign item_valid   = (count_reg != 2'd0);
    assign pop          = item_valid && item_ready;
    assign item         = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: rtl/tcbe_div.sv
// ----------------------------------------------------------------------------
// tcbe_div
// radix-2 restoring divider, quotient saturated at 32 bits
// ----------------------------------------------------------------------------
module tcbe_div
    import tcbe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [RATE_W-1:0] q_reg;
    logic              sat_reg;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            sat_reg <= sat_reg | q_reg[RATE_W-1];
            q_reg   <= {q_reg[RATE_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = sat_reg ? '1 : q_reg;

endmodule

// File: rtl/tcbe_core.sv
// ----------------------------------------------------------------------------
// tcbe_core
// per-pid context, continuity check, rate sampling and averaging
// ----------------------------------------------------------------------------
module tcbe_core
    import tcbe_pkg::*;
#(
    parameter int PID_COUNT = 8192
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg_q,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_data,
    output div_req_t              div_req,
    input  div_rsp_t              div_rsp
);

    localparam int AW = $clog2(PID_COUNT);

    cnt_row_t cnt_mem [PID_COUNT];
    clk_row_t clk_mem [PID_COUNT];

    state_t            state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    cfg_t              cfg_reg, cfg_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [PKT_W-1:0]  pc_reg, pc_next;
    logic [SUM_W-1:0]  sum188_reg, sum188_next;
    logic [SUM_W-1:0]  sum204_reg, sum204_next;
    logic [RATE_W-1:0] samples_reg, samples_next;
    logic [PIDN_W-1:0] completed_reg, completed_next;
    logic [PIDN_W-1:0] clock_pids_reg, clock_pids_next;
    logic              vflag_reg, vflag_next;
    logic [RATE_W-1:0] avg188_reg, avg188_next;
    logic [RATE_W-1:0] avg204_reg, avg204_next;
    logic              div_run_reg, div_run_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    item_t             item_reg;
    cnt_row_t          cnt_rd_reg;
    clk_row_t          clk_rd_reg;
    logic [PKT_W-1:0]  pk_reg, pk_next;
    logic [CLK_W-1:0]  dclk_reg, dclk_next;
    logic [PCNT_W-1:0] pid_pk_reg, pid_pk_next;
    logic [PROD_W-1:0] prod188_reg, prod188_next;
    logic [PROD_W-1:0] prod204_reg, prod204_next;
    logic [NUM_W-1:0]  num188_reg, num188_next;
    logic [NUM_W-1:0]  num204_reg, num204_next;
    logic [RATE_W-1:0] r188_reg, r188_next;
    logic [RATE_W-1:0] r204_reg, r204_next;

    logic              take;
    logic              cnt_we, clk_we;
    logic [AW-1:0]     cnt_wa, clk_wa;
    cnt_row_t          cnt_wd;
    clk_row_t          clk_wd;

    // evaluation terms
    logic              in_range, bad_sync, work, broken, invalidate;
    logic [PKT_W-1:0]  pc_new;
    logic [PCNT_W-1:0] pkt_new;
    logic [CC_W-1:0]   cc_inc;
    logic [CLK_W-1:0]  last_eff;
    logic              take_sample, clk_write, smp_inc, completes;
    logic [SMP_W-1:0]  smp_new, need;
    logic [PIDN_W-1:0] needp, completed_new;
    logic              sweep_last;

    assign cfg_q      = cfg_reg;
    assign item_ready = (state_reg == ST_IDLE);
    assign take       = item_valid && item_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;
    assign sweep_last = (sweep_reg == AW'(PID_COUNT - 1));

    always_comb
    begin
        in_range   = ({1'b0, item_reg.pid} < PIDN_W'(PID_COUNT));
        pc_new     = pc_reg + PKT_W'(1);
        bad_sync   = !cfg_reg.ignore_errors && !item_reg.sync_ok;
        work       = !bad_sync && in_range;
        pkt_new    = (cnt_rd_reg.pkts == '1) ? cnt_rd_reg.pkts : cnt_rd_reg.pkts + PCNT_W'(1);
        cc_inc     = cnt_rd_reg.cc + CC_W'(1);
        broken     = work && !cfg_reg.ignore_errors && (pkt_new != PCNT_W'(1)) &&
                     (item_reg.disc ||
                      (item_reg.payload ? (item_reg.cc != cnt_rd_reg.cc && item_reg.cc != cc_inc)
                                        : (item_reg.cc != cnt_rd_reg.cc)));
        invalidate = bad_sync || broken;
        last_eff   = (invalidate || clk_rd_reg.epoch != epoch_reg) ? '0 : clk_rd_reg.clk;
        take_sample = work && item_reg.has_clk && (last_eff != '0) && (last_eff < item_reg.clk);
        clk_write  = work && item_reg.has_clk && (last_eff != item_reg.clk);
        need       = (cfg_reg.min_clock_samples == '0) ? SMP_W'(1) : cfg_reg.min_clock_samples;
        needp      = (cfg_reg.min_pids == '0) ? PIDN_W'(1) : cfg_reg.min_pids;
        smp_inc    = take_sample && (cnt_rd_reg.smp != '1);
        smp_new    = smp_inc ? cnt_rd_reg.smp + SMP_W'(1) : cnt_rd_reg.smp;
        completes  = smp_inc && (smp_new == need);
        completed_new = completed_reg + PIDN_W'(completes);
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        cfg_next        = cfg_reg;
        epoch_next      = epoch_reg;
        pc_next         = pc_reg;
        sum188_next     = sum188_reg;
        sum204_next     = sum204_reg;
        samples_next    = samples_reg;
        completed_next  = completed_reg;
        clock_pids_next = clock_pids_reg;
        vflag_next      = vflag_reg;
        avg188_next     = avg188_reg;
        avg204_next     = avg204_reg;
        div_run_next    = div_run_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        pk_next         = pk_reg;
        dclk_next       = dclk_reg;
        pid_pk_next     = pid_pk_reg;
        prod188_next    = prod188_reg;
        prod204_next    = prod204_reg;
        num188_next     = num188_reg;
        num204_next     = num204_reg;
        r188_next       = r188_reg;
        r204_next       = r204_reg;
        cnt_we          = 1'b0;
        clk_we          = 1'b0;
        cnt_wa          = item_reg.pid[AW-1:0];
        clk_wa          = item_reg.pid[AW-1:0];
        cnt_wd          = '0;
        clk_wd          = '0;
        div_req.start   = 1'b0;
        div_req.num     = num188_reg;
        div_req.den     = dclk_reg;

        // configuration writes are taken in any state
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_USE_DTS:           cfg_next.use_dts = cfg_data[0];
                REG_IGNORE_ERRORS:     cfg_next.ignore_errors = cfg_data[0];
                REG_MIN_PIDS:          cfg_next.min_pids = cfg_data[PIDN_W-1:0];
                REG_MIN_CLOCK_SAMPLES: cfg_next.min_clock_samples = cfg_data[SMP_W-1:0];
                default:               ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                cnt_we = 1'b1;
                clk_we = 1'b1;
                cnt_wa = sweep_reg;
                clk_wa = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_last)
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (invalidate && epoch_reg == '1)
                begin
                    // epoch space used up: forget all stored clocks first
                    sweep_next = '0;
                    state_next = ST_WIPE;
                end
                else
                begin
                    epoch_next = invalidate ? epoch_reg + EPOCH_W'(1) : epoch_reg;
                    pc_next    = pc_new;
                    pid_pk_next = work ? pkt_new : (in_range ? cnt_rd_reg.pkts : '0);
                    if (work)
                    begin
                        cnt_we      = 1'b1;
                        cnt_wd.pkts = pkt_new;
                        cnt_wd.cc   = cfg_reg.ignore_errors ? cnt_rd_reg.cc : item_reg.cc;
                        cnt_wd.smp  = smp_new;
                    end
                    if (clk_write)
                    begin
                        clk_we       = 1'b1;
                        clk_wd.epoch = epoch_next;
                        clk_wd.clk   = item_reg.clk;
                        clk_wd.pkt   = pc_new;
                    end
                    if (smp_inc && smp_new == SMP_W'(1))
                    begin
                        clock_pids_next = clock_pids_reg + PIDN_W'(1);
                    end
                    if (completes)
                    begin
                        completed_next = completed_new;
                        vflag_next     = (completed_new >= needp);
                    end
                    pk_next    = pc_new - clk_rd_reg.pkt;
                    dclk_next  = item_reg.clk - last_eff;
                    state_next = take_sample ? ST_MUL0 : ST_OUT;
                end
            end
            ST_WIPE:
            begin
                clk_we = 1'b1;
                clk_wa = sweep_reg;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_last)
                begin
                    sweep_next = '0;
                    epoch_next = '0;
                    state_next = ST_EVAL;
                end
            end
            ST_MUL0:
            begin
                prod188_next = pk_reg[MUL_SPLIT-1:0] * RATE_K188;
                prod204_next = pk_reg[MUL_SPLIT-1:0] * RATE_K204;
                state_next   = ST_MUL1;
            end
            ST_MUL1:
            begin
                num188_next  = NUM_W'(prod188_reg);
                num204_next  = NUM_W'(prod204_reg);
                prod188_next = pk_reg[PKT_W-1:MUL_SPLIT] * RATE_K188;
                prod204_next = pk_reg[PKT_W-1:MUL_SPLIT] * RATE_K204;
                state_next   = ST_MUL2;
            end
            ST_MUL2:
            begin
                num188_next = num188_reg + (NUM_W'(prod188_reg) << MUL_SPLIT);
                num204_next = num204_reg + (NUM_W'(prod204_reg) << MUL_SPLIT);
                state_next  = ST_DIV188;
            end
            ST_DIV188:
            begin
                div_req.start = !div_run_reg;
                div_run_next  = 1'b1;
                if (div_run_reg && div_rsp.done)
                begin
                    r188_next    = div_rsp.quo;
                    div_run_next = 1'b0;
                    state_next   = ST_DIV204;
                end
            end
            ST_DIV204:
            begin
                div_req.start = !div_run_reg;
                div_req.num   = num204_reg;
                div_run_next  = 1'b1;
                if (div_run_reg && div_rsp.done)
                begin
                    r204_next    = div_rsp.quo;
                    div_run_next = 1'b0;
                    state_next   = ST_ACC;
                end
            end
            ST_ACC:
            begin
                sum188_next  = sum188_reg + SUM_W'(r188_reg);
                sum204_next  = sum204_reg + SUM_W'(r204_reg);
                samples_next = samples_reg + RATE_W'(1);
                if (samples_next == '0)
                begin
                    avg188_next = '0;
                    avg204_next = '0;
                    state_next  = ST_OUT;
                end
                else
                begin
                    state_next = ST_AVG188;
                end
            end
            ST_AVG188:
            begin
                div_req.start = !div_run_reg;
                div_req.num   = NUM_W'(sum188_reg);
                div_req.den   = DEN_W'(samples_reg);
                div_run_next  = 1'b1;
                if (div_run_reg && div_rsp.done)
                begin
                    avg188_next  = div_rsp.quo;
                    div_run_next = 1'b0;
                    state_next   = ST_AVG204;
                end
            end
            ST_AVG204:
            begin
                div_req.start = !div_run_reg;
                div_req.num   = NUM_W'(sum204_reg);
                div_req.den   = DEN_W'(samples_reg);
                div_run_next  = 1'b1;
                if (div_run_reg && div_rsp.done)
                begin
                    avg204_next  = div_rsp.quo;
                    div_run_next = 1'b0;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.rate_valid        = vflag_reg;
                    out_next.avg_rate_188      = avg188_reg;
                    out_next.avg_rate_204      = avg204_reg;
                    out_next.packet_total      = pc_reg;
                    out_next.rate_sample_total = samples_reg;
                    out_next.clock_pid_total   = clock_pids_reg;
                    out_next.pid_packets       = pid_pk_reg;
                    out_valid_next             = 1'b1;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            cfg_reg.use_dts           <= 1'b0;
            cfg_reg.ignore_errors     <= 1'b0;
            cfg_reg.min_pids          <= PIDN_W'(1);
            cfg_reg.min_clock_samples <= SMP_W'(1);
            epoch_reg      <= EPOCH_W'(1);
            pc_reg         <= '0;
            sum188_reg     <= '0;
            sum204_reg     <= '0;
            samples_reg    <= '0;
            completed_reg  <= '0;
            clock_pids_reg <= '0;
            vflag_reg      <= 1'b0;
            avg188_reg     <= '0;
            avg204_reg     <= '0;
            div_run_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            cfg_reg        <= cfg_next;
            epoch_reg      <= epoch_next;
            pc_reg         <= pc_next;
            sum188_reg     <= sum188_next;
            sum204_reg     <= sum204_next;
            samples_reg    <= samples_next;
            completed_reg  <= completed_next;
            clock_pids_reg <= clock_pids_next;
            vflag_reg      <= vflag_next;
            avg188_reg     <= avg188_next;
            avg204_reg     <= avg204_next;
            div_run_reg    <= div_run_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        pk_reg      <= pk_next;
        dclk_reg    <= dclk_next;
        pid_pk_reg  <= pid_pk_next;
        prod188_reg <= prod188_next;
        prod204_reg <= prod204_next;
        num188_reg  <= num188_next;
        num204_reg  <= num204_next;
        r188_reg    <= r188_next;
        r204_reg    <= r204_next;
        if (take)
        begin
            item_reg <= item;
        end
    end

    // per-pid context memories
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (take)
        begin
            cnt_rd_reg <= cnt_mem[item.pid[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clk_we)
        begin
            clk_mem[clk_wa] <= clk_wd;
        end
        if (take)
        begin
            clk_rd_reg <= clk_mem[item.pid[AW-1:0]];
        end
    end

endmodule

// File: rtl/ts_clock_bitrate_estimator.sv
// flow: a packet with no rate sample passes through EVAL and OUT; one that does
//   also passes MUL0 to MUL2, two rate divisions, ACC and two average divisions
// pacing: a new packet is taken only once the last result is registered;
//   one packet at a time in the core, a 2-entry queue takes headers meanwhile
// reset: a pass over every pid clears the per-pid memories, no packet taken then;
//   a clock invalidation in the last epoch runs a like pass on the clock memory
// ----------------------------------------------------------------------------
// ts_clock_bitrate_estimator
// transport stream bitrate estimation from per-pid pcr or dts clocks
// ----------------------------------------------------------------------------
module ts_clock_bitrate_estimator
    import tcbe_pkg::*;
#(
    parameter int PID_COUNT = 8192
)
(
    input  logic        clk,
    input  logic        rst_n,
    tcbe_in_if.sink     pkt_in,
    tcbe_out_if.source  res_out,
    tcbe_cfg_if.sink    cfg
);

    cfg_t     cfg_q;
    logic     item_valid;
    logic     item_ready;
    item_t    item;
    result_t  res;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // configuration registers live in the core, always writable
    assign cfg.ready = 1'b1;

    // front end: clock selection and header queue
    tcbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_in     (pkt_in),
        .cfg        (cfg_q),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // shared divider for rate and average quotients
    tcbe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // back end: per-pid context, continuity and rate accounting
    tcbe_core #(
        .PID_COUNT (PID_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .cfg_q      (cfg_q),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .out_valid  (res_out.valid),
        .out_ready  (res_out.ready),
        .out_data   (res),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    // result register fields onto the output channel
    assign res_out.rate_valid        = res.rate_valid;
    assign res_out.avg_rate_188      = res.avg_rate_188;
    assign res_out.avg_rate_204      = res.avg_rate_204;
    assign res_out.packet_total      = res.packet_total;
    assign res_out.rate_sample_total = res.rate_sample_total;
    assign res_out.clock_pid_total   = res.clock_pid_total;
    assign res_out.pid_packets       = res.pid_packets;

endmodule

// File: rtl/tcbe_checker.sv
// ----------------------------------------------------------------------------
// tcbe_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
module tcbe_checker
    import tcbe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [RATE_W-1:0] avg188,
    input logic [RATE_W-1:0] avg204,
    input logic [PKT_W-1:0]  packet_total,
    input logic [RATE_W-1:0] sample_total
);

    logic              seen_reg;
    logic [PKT_W-1:0]  last_pt_reg;
    logic [RATE_W-1:0] last_st_reg;
    logic              out_acc;

    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            last_pt_reg <= '0;
            last_st_reg <= '0;
        end
        else if (out_acc)
        begin
            seen_reg    <= 1'b1;
            last_pt_reg <= packet_total;
            last_st_reg <= sample_total;
        end
    end

    // one result per packet, in order
    a_first_pt: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !seen_reg |-> packet_total == PKT_W'(1))
        else $error("first result does not count one packet");

    a_pt_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_reg |-> packet_total == last_pt_reg + PKT_W'(1))
        else $error("packet total skipped or repeated");

    a_st_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_reg |->
            (sample_total == last_st_reg) || (sample_total == last_st_reg + RATE_W'(1)))
        else $error("more than one rate sample per packet");

    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && sample_total == '0 |-> avg188 == '0 && avg204 == '0)
        else $error("nonzero average without samples");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packet_total))
        else $error("result dropped while stalled");

endmodule

bind ts_clock_bitrate_estimator tcbe_checker u_tcbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (res_out.valid),
    .out_ready    (res_out.ready),
    .avg188       (res_out.avg_rate_188),
    .avg204       (res_out.avg_rate_204),
    .packet_total (res_out.packet_total),
    .sample_total (res_out.rate_sample_total)
);

// File: tb/sv/ts_clock_bitrate_estimator_tb.sv
// ----------------------------------------------------------------------------
// ts_clock_bitrate_estimator_tb
// drives parsed transport packet headers into the bitrate estimator, predicts
// every result from a local copy of the per-pid and global state, and checks
// each result transaction field by field
// ----------------------------------------------------------------------------
module ts_clock_bitrate_estimator_tb;
    import tcbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NPID      = 8192;
    localparam int          SETTLE    = NPID + 400;    // wipe pass plus a rate sample
    localparam longint      LIMIT     = 6000000;
    localparam longint unsigned PCR_MAX = 64'd2576980377599;
    localparam longint unsigned DTS_MAX = 64'd8589934591;
    localparam int          NSTREAM   = 4;

    // one packet header as the input channel carries it
    typedef struct {
        bit                 sync_ok;
        bit [PID_W-1:0]     pid;
        bit [CC_W-1:0]      cc;
        bit                 disc;
        bit                 payload;
        bit                 has_pcr;
        bit [CLK_W-1:0]     pcr;
        bit                 has_dts;
        bit [DTS_W-1:0]     dts;
    } hdr_t;

    logic clk;
    logic rst_n;

    tcbe_in_if  pin();
    tcbe_out_if rout();
    tcbe_cfg_if cfg();

    ts_clock_bitrate_estimator #(.PID_COUNT(NPID)) u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt_in  (pin.sink),
        .res_out (rout.source),
        .cfg     (cfg.sink)
    );

    // ------------------------------------------------------------------
    // estimator state as the predictor sees it
    // ------------------------------------------------------------------
    bit                 use_dts_r;
    bit                 ign_err_r;
    bit [PIDN_W-1:0]    min_pids_r;
    bit [SMP_W-1:0]     min_smp_r;

    bit [PCNT_W-1:0]    pid_pkts    [NPID];
    bit [CC_W-1:0]      pid_cc      [NPID];
    bit [CLK_W-1:0]     pid_clk     [NPID];
    bit [PKT_W-1:0]     pid_clk_pkt [NPID];
    bit [SMP_W-1:0]     pid_smp     [NPID];
    bit [PKT_W-1:0]     pkt_cnt;
    bit [SUM_W-1:0]     sum188;
    bit [SUM_W-1:0]     sum204;
    bit [RATE_W-1:0]    smp_cnt;
    bit [PIDN_W-1:0]    done_pids;
    bit [PIDN_W-1:0]    clk_pids;
    bit                 valid_r;

    result_t            expected_results[$];
    hdr_t               pending_hdrs[$];

    int                 fails;
    int                 n_accepted;
    int                 n_wipes;
    longint             cycles;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // quotient saturated to 32 bits
    function automatic bit [RATE_W-1:0] sat_div(bit [127:0] num, bit [127:0] den);
        bit [127:0] q;
        q = num / den;
        return (q > 128'hFFFF_FFFF) ? '1 : q[RATE_W-1:0];
    endfunction

    function automatic void wipe_clocks();
        foreach (pid_clk[i]) pid_clk[i] = '0;
        n_wipes++;
    endfunction

    function automatic result_t bitrate_update(hdr_t h);
        result_t        r;
        bit [PCNT_W-1:0] pk_pid;
        bit             broken;
        bit [CLK_W-1:0] clk_v;
        bit [CLK_W-1:0] last;
        bit [PKT_W-1:0] pk;
        bit [RATE_W-1:0] r188;
        bit [RATE_W-1:0] r204;
        bit [SMP_W-1:0] need;
        bit [PIDN_W-1:0] needp;

        pkt_cnt = pkt_cnt + 1'b1;
        pk_pid  = '0;
        if (!ign_err_r && !h.sync_ok)
        begin
            wipe_clocks();
            pk_pid = pid_pkts[h.pid];
        end
        else
        begin
            if (pid_pkts[h.pid] != '1) pid_pkts[h.pid]++;
            pk_pid = pid_pkts[h.pid];
            if (!ign_err_r)
            begin
                // first packet of a pid never breaks continuity
                if (pk_pid == 1)
                    broken = 1'b0;
                else if (h.disc)
                    broken = 1'b1;
                else if (h.payload)
                    broken = h.cc != pid_cc[h.pid] && h.cc != pid_cc[h.pid] + 1'b1;
                else
                    broken = h.cc != pid_cc[h.pid];
                pid_cc[h.pid] = h.cc;
                if (broken) wipe_clocks();
            end
            if (use_dts_r ? h.has_dts : h.has_pcr)
            begin
                clk_v = use_dts_r ? CLK_W'(h.dts) * CLK_SUBFACTOR : h.pcr;
                last  = pid_clk[h.pid];
                if (last != 0 && last < clk_v)
                begin
                    pk   = pkt_cnt - pid_clk_pkt[h.pid];
                    r188 = sat_div(128'(pk) * 128'(RATE_K188), 128'(clk_v - last));
                    r204 = sat_div(128'(pk) * 128'(RATE_K204), 128'(clk_v - last));
                    need  = (min_smp_r == 0) ? SMP_W'(1) : min_smp_r;
                    needp = (min_pids_r == 0) ? PIDN_W'(1) : min_pids_r;
                    if (pid_smp[h.pid] != '1)
                    begin
                        pid_smp[h.pid]++;
                        if (pid_smp[h.pid] == 1) clk_pids++;
                        if (pid_smp[h.pid] == need)
                        begin
                            done_pids++;
                            valid_r = done_pids >= needp;
                        end
                    end
                    sum188  += r188;
                    sum204  += r204;
                    smp_cnt++;
                end
                // zero clock is stored but reads as no clock afterwards
                if (last != clk_v)
                begin
                    pid_clk[h.pid]     = clk_v;
                    pid_clk_pkt[h.pid] = pkt_cnt;
                end
            end
        end

        r.rate_valid        = valid_r;
        r.avg_rate_188      = smp_cnt ? sat_div(128'(sum188), 128'(smp_cnt)) : '0;
        r.avg_rate_204      = smp_cnt ? sat_div(128'(sum204), 128'(smp_cnt)) : '0;
        r.packet_total      = pkt_cnt;
        r.rate_sample_total = smp_cnt;
        r.clock_pid_total   = clk_pids;
        r.pid_packets       = pk_pid;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and cycle limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // packet driver: gaps drawn per transaction, stretches with none
    // ------------------------------------------------------------------
    bit  in_took;
    bit  in_busy;
    bit  calm;          // when set, neither side idles
    int  in_gap;
    hdr_t cur;

    always @(posedge clk)
    begin
        if (rst_n && pin.valid && pin.ready)
        begin
            expected_results.push_back(bitrate_update(cur));
            n_accepted++;
            in_took = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_took)
            begin
                in_took = 1'b0;
                in_busy = 1'b0;
                in_gap  = calm ? 0 : $urandom_range(0, 15);
            end
            if (!in_busy)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending_hdrs.size() > 0)
                begin
                    cur = pending_hdrs.pop_front();
                    pin.sync_ok      <= cur.sync_ok;
                    pin.pid          <= cur.pid;
                    pin.cont_counter <= cur.cc;
                    pin.disc_flag    <= cur.disc;
                    pin.has_payload  <= cur.payload;
                    pin.has_pcr      <= cur.has_pcr;
                    pin.pcr_value    <= cur.pcr;
                    pin.has_dts      <= cur.has_dts;
                    pin.dts_value    <= cur.dts;
                    in_busy = 1'b1;
                end
            end
            pin.valid <= in_busy;
        end
    end

    // ------------------------------------------------------------------
    // result monitor with random back-pressure
    // ------------------------------------------------------------------
    bit  out_took;
    int  out_stall;

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && rout.valid && rout.ready)
        begin
            out_took = 1'b1;
            got.rate_valid        = rout.rate_valid;
            got.avg_rate_188      = rout.avg_rate_188;
            got.avg_rate_204      = rout.avg_rate_204;
            got.packet_total      = rout.packet_total;
            got.rate_sample_total = rout.rate_sample_total;
            got.clock_pid_total   = rout.clock_pid_total;
            got.pid_packets       = rout.pid_packets;
            if (expected_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fails++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.rate_valid !== want.rate_valid)
                begin
                    $error("rate_valid exp %0d got %0d", want.rate_valid, got.rate_valid);
                    fails++;
                end
                if (got.avg_rate_188 !== want.avg_rate_188)
                begin
                    $error("avg_rate_188 exp %0d got %0d", want.avg_rate_188, got.avg_rate_188);
                    fails++;
                end
                if (got.avg_rate_204 !== want.avg_rate_204)
                begin
                    $error("avg_rate_204 exp %0d got %0d", want.avg_rate_204, got.avg_rate_204);
                    fails++;
                end
                if (got.packet_total !== want.packet_total)
                begin
                    $error("packet_total exp %0d got %0d", want.packet_total, got.packet_total);
                    fails++;
                end
                if (got.rate_sample_total !== want.rate_sample_total)
                begin
                    $error("rate_sample_total exp %0d got %0d",
                           want.rate_sample_total, got.rate_sample_total);
                    fails++;
                end
                if (got.clock_pid_total !== want.clock_pid_total)
                begin
                    $error("clock_pid_total exp %0d got %0d",
                           want.clock_pid_total, got.clock_pid_total);
                    fails++;
                end
                if (got.pid_packets !== want.pid_packets)
                begin
                    $error("pid_packets exp %0d got %0d", want.pid_packets, got.pid_packets);
                    fails++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
            begin
                out_took  = 1'b0;
                out_stall = calm ? 0 : $urandom_range(0, 15);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                rout.ready <= 1'b0;
            end
            else
                rout.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    // generator shadow: which pids were counted while checks were off and
    // which have a known continuity counter; a pid counted with checks off
    // and never given a counter must not be hit once checks are back on
    bit                 touched  [NPID];
    bit                 cc_known [NPID];
    bit [PID_W-1:0]     act_pid  [NSTREAM];
    bit [CC_W-1:0]      act_cc   [NSTREAM];
    longint unsigned    act_pcr  [NSTREAM];
    longint unsigned    act_dts  [NSTREAM];
    bit                 gen_ign;

    function automatic bit pid_safe(bit [PID_W-1:0] p);
        return gen_ign || !touched[p] || cc_known[p];
    endfunction

    function automatic void queue_hdr(hdr_t h);
        if (gen_ign || !h.sync_ok)
        begin
            if (gen_ign) touched[h.pid] = 1'b1;
        end
        else
        begin
            touched[h.pid]  = 1'b1;
            cc_known[h.pid] = 1'b1;
        end
        pending_hdrs.push_back(h);
    endfunction

    function automatic bit [PID_W-1:0] safe_pid();
        bit [PID_W-1:0] p;
        p = PID_W'($urandom_range(0, NPID - 1));
        while (!pid_safe(p)) p = PID_W'($urandom_range(0, NPID - 1));
        return p;
    endfunction

    function automatic longint unsigned rand64(longint unsigned top);
        return {$urandom, $urandom} % (top + 1);
    endfunction

    // fully random header, safe pid
    function automatic hdr_t noise_hdr();
        hdr_t h;
        h.sync_ok = $urandom_range(0, 3) != 0;
        h.pid     = safe_pid();
        h.cc      = CC_W'($urandom);
        h.disc    = 1'($urandom);
        h.payload = 1'($urandom);
        h.has_pcr = 1'($urandom);
        h.pcr     = CLK_W'(rand64(PCR_MAX));
        h.has_dts = 1'($urandom);
        h.dts     = DTS_W'(rand64(DTS_MAX));
        return h;
    endfunction

    // mostly well-formed packet of one of the active streams
    function automatic hdr_t stream_hdr(int s);
        hdr_t h;
        int   pick;
        h.sync_ok = $urandom_range(0, 99) >= 2;
        h.pid     = act_pid[s];
        h.payload = $urandom_range(0, 9) != 0;
        if (h.payload) act_cc[s] = act_cc[s] + 1'b1;
        h.cc      = act_cc[s];
        h.disc    = $urandom_range(0, 99) < 3;
        h.has_pcr = 1'($urandom_range(0, 1));
        h.has_dts = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 19);
        // mostly realistic spacing, sometimes tiny steps that saturate, sometimes a random jump
        if (pick == 0)
        begin
            act_pcr[s] = rand64(PCR_MAX);
            act_dts[s] = rand64(DTS_MAX);
        end
        else if (pick == 1)
        begin
            act_pcr[s] = (act_pcr[s] + 1) % (PCR_MAX + 1);
            act_dts[s] = (act_dts[s] + 1) % (DTS_MAX + 1);
        end
        else
        begin
            act_pcr[s] = (act_pcr[s] + $urandom_range(1000, 3000000)) % (PCR_MAX + 1);
            act_dts[s] = (act_dts[s] + $urandom_range(4, 10000)) % (DTS_MAX + 1);
        end
        h.pcr = CLK_W'(act_pcr[s]);
        h.dts = DTS_W'(act_dts[s]);
        return h;
    endfunction

    task automatic random_items(int n);
        int s;
        for (int k = 0; k < n; k++)
        begin
            if (k % 100 == 0) calm = $urandom_range(0, 3) == 0;
            s = $urandom_range(0, NSTREAM - 1);
            if ($urandom_range(0, 9) == 0 || !pid_safe(act_pid[s]))
                queue_hdr(noise_hdr());
            else
                queue_hdr(stream_hdr(s));
        end
    endtask

    // pick fresh active pids for a phase
    function automatic void new_streams();
        for (int s = 0; s < NSTREAM; s++)
        begin
            act_pid[s] = safe_pid();
            act_cc[s]  = CC_W'($urandom);
            act_pcr[s] = rand64(PCR_MAX / 2);
            act_dts[s] = rand64(DTS_MAX / 2);
        end
    endfunction

    task automatic wait_idle();
        wait (pending_hdrs.size() == 0 && !in_busy && expected_results.size() == 0);
        // any clock-memory wipe ends before the result of its packet
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            REG_USE_DTS:           use_dts_r  = value[0];
            REG_IGNORE_ERRORS:     ign_err_r  = value[0];
            REG_MIN_PIDS:          min_pids_r = value[PIDN_W-1:0];
            REG_MIN_CLOCK_SAMPLES: min_smp_r  = value[SMP_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_regs(bit dts, bit ign, int unsigned mp, int unsigned ms);
        wait_idle();
        write_reg(REG_USE_DTS, dts);
        write_reg(REG_IGNORE_ERRORS, ign);
        write_reg(REG_MIN_PIDS, mp);
        write_reg(REG_MIN_CLOCK_SAMPLES, ms);
        gen_ign = ign;
        new_streams();
    endtask

    function automatic hdr_t mk(bit sync_ok, bit [PID_W-1:0] pid, bit [CC_W-1:0] cc,
                                bit disc, bit payload, bit has_pcr,
                                longint unsigned pcr, bit has_dts, longint unsigned dts);
        hdr_t h;
        h.sync_ok = sync_ok;
        h.pid     = pid;
        h.cc      = cc;
        h.disc    = disc;
        h.payload = payload;
        h.has_pcr = has_pcr;
        h.pcr     = CLK_W'(pcr);
        h.has_dts = has_dts;
        h.dts     = DTS_W'(dts);
        return h;
    endfunction

    initial
    begin
        // known values on every input from time zero
        rst_n     = 1'b0;
        pin.valid = 1'b0;
        pin.sync_ok = 1'b0;
        pin.pid = '0;
        pin.cont_counter = '0;
        pin.disc_flag = 1'b0;
        pin.has_payload = 1'b0;
        pin.has_pcr = 1'b0;
        pin.pcr_value = '0;
        pin.has_dts = 1'b0;
        pin.dts_value = '0;
        rout.ready = 1'b0;
        cfg.valid  = 1'b0;
        cfg.index  = REG_USE_DTS;
        cfg.data   = '0;

        // predictor reset state, registers at their reset values
        use_dts_r  = 1'b0;
        ign_err_r  = 1'b0;
        min_pids_r = PIDN_W'(1);
        min_smp_r  = SMP_W'(1);
        gen_ign    = 1'b0;
        calm       = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes and special cases, pcr clock, defaults
        queue_hdr(mk(1, 13'd0,    4'd0,  0, 1, 1, 64'd1,        0, 0));
        queue_hdr(mk(1, 13'd0,    4'd1,  0, 1, 1, 64'd27000000, 0, 0));    // first sample
        queue_hdr(mk(1, 13'd0,    4'd1,  0, 0, 1, 64'd27000000, 0, 0));    // equal clock
        queue_hdr(mk(1, 13'd0,    4'd1,  0, 0, 1, 64'd1000,     0, 0));    // smaller clock
        queue_hdr(mk(1, 13'd0,    4'd2,  0, 1, 1, 64'd1001,     0, 0));    // tiny step, saturates
        queue_hdr(mk(1, 13'd8191, 4'd15, 1, 0, 1, PCR_MAX - 5,  1, DTS_MAX));
        queue_hdr(mk(1, 13'd8191, 4'd0,  0, 1, 1, PCR_MAX,      0, 0));    // cc wrap 15 to 0
        queue_hdr(mk(1, 13'd0,    4'd3,  0, 1, 1, 64'd0,        0, 0));    // zero clock stored
        queue_hdr(mk(1, 13'd0,    4'd4,  0, 1, 1, 64'd5000,     0, 0));    // zero reads as none
        queue_hdr(mk(1, 13'd0,    4'd5,  0, 1, 1, 64'd9000,     0, 0));
        queue_hdr(mk(0, 13'd0,    4'd9,  1, 1, 1, 64'd20000,    1, 64'd1)); // bad sync wipes
        queue_hdr(mk(1, 13'd0,    4'd6,  0, 1, 1, 64'd30000,    0, 0));
        queue_hdr(mk(1, 13'd0,    4'd6,  1, 1, 1, 64'd40000,    0, 0));    // discontinuity
        queue_hdr(mk(1, 13'd0,    4'd9,  0, 1, 1, 64'd50000,    0, 0));    // cc jump breaks
        queue_hdr(mk(1, 13'd0,    4'd8,  0, 0, 1, 64'd60000,    0, 0));    // no payload, cc moved
        queue_hdr(mk(1, 13'd0,    4'd8,  0, 0, 1, 64'd70000,    0, 0));
        queue_hdr(mk(1, 13'd5461, 4'd10, 0, 1, 0, 64'h2AA_AAAA_AAAA, 1, 64'h1_5555_5555));
        queue_hdr(mk(1, 13'd2730, 4'd5,  0, 0, 1, 64'h155_5555_5555, 0, 64'h0_AAAA_AAAA));
        new_streams();
        random_items(230);

        // dts clock, several samples per pid
        set_regs(1, 0, 2, 3);
        queue_hdr(mk(1, 13'd100, 4'd0, 0, 1, 0, 0, 1, 64'd1));
        queue_hdr(mk(1, 13'd100, 4'd1, 0, 1, 0, 0, 1, DTS_MAX));
        queue_hdr(mk(1, 13'd100, 4'd2, 0, 1, 0, 0, 1, 64'd0));
        random_items(250);

        // checks off, largest thresholds
        set_regs(0, 1, 8192, 65535);
        random_items(200);

        // zero thresholds act as one
        set_regs(1, 1, 0, 0);
        random_items(150);

        // checks back on; the sender drains everything once mid-phase
        set_regs(0, 0, 3, 2);
        random_items(150);
        wait (pending_hdrs.size() == 0 && !in_busy && expected_results.size() == 0);
        random_items(150);

        set_regs(1, 0, 1, 65535);
        random_items(150);

        wait (pending_hdrs.size() == 0 && !in_busy && expected_results.size() == 0);
        repeat (SETTLE) @(posedge clk);

        $display("tb: %0d packet headers checked over 6 register settings", n_accepted);
        $display("tb: %0d rate samples, %0d clock wipes predicted", smp_cnt, n_wipes);
        if (fails == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/tcbe_pkg.sv
rtl/tcbe_if.sv
rtl/tcbe_front.sv
rtl/tcbe_div.sv
rtl/tcbe_core.sv
rtl/ts_clock_bitrate_estimator.sv
rtl/tcbe_checker.sv
tb/sv/ts_clock_bitrate_estimator_tb.sv
